// ===== src/fat_chain_extent_translator_top_assert.svh =====
// Assertion macros for the FAT chain extent translator.
`ifndef FAT_CHAIN_EXTENT_TRANSLATOR_TOP_ASSERT_SVH
`define FAT_CHAIN_EXTENT_TRANSLATOR_TOP_ASSERT_SVH

// Same-cycle implication under synchronous reset.
`define FCET_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcet assertion failed");

// Next-cycle implication under synchronous reset.
`define FCET_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcet assertion failed");

`endif

// ===== src/fcet_pkg.sv =====
// Shared types and constants of the FAT chain extent translator.
package fcet_pkg;

   localparam int MAX_EXTENTS_DEF    = 1024;
   localparam int MAX_REQUEST_BLOCKS = 48;
   localparam int CSR_IW             = 3;
   localparam int CSR_DW             = 32;

   localparam logic [CSR_IW-1:0] CSR_DATA_BASE   = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_SPC         = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_LIMIT       = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_CAPACITY    = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_START       = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_FAT32       = 3'd5;
   localparam logic [CSR_IW-1:0] CSR_READ_ONLY   = 3'd6;

   localparam logic [27:0] FAT32_MASK = 28'hFFF_FFFF;

   typedef enum logic [1:0] {
      FUNC_BUILD = 2'd0,
      FUNC_ENTRY = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_WRITE = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      RS_ACCESS    = 3'd0,
      RS_NEED      = 3'd1,
      RS_READY     = 3'd2,
      RS_FAILED    = 3'd3,
      RS_NOT_READY = 3'd4,
      RS_BAD_COUNT = 3'd5,
      RS_RANGE     = 3'd6,
      RS_READ_ONLY = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_BUILD  = 2'd1,
      MODE_READY  = 2'd2,
      MODE_FAILED = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LMUL,
      ST_ADV,
      ST_PMUL,
      ST_PWR,
      ST_CHAIN,
      ST_RCHK,
      ST_SSTEP,
      ST_SWAIT,
      ST_SCMP,
      ST_SOFF,
      ST_SEMIT,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [31:0] first_block;
      logic [31:0] phys_start;
      logic [31:0] length;
   } extent_type;

endpackage

// ===== src/fcet_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface fcet_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [31:0] entry_value;
   logic [31:0] block;
   logic [31:0] blk_count;
   modport source (output valid, func, entry_value, block, blk_count, input ready);
   modport sink (input valid, func, entry_value, block, blk_count, output ready);
endinterface

interface fcet_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] phys_lba;
   logic [5:0]  sector_count;
   logic [27:0] need_cluster;
   logic        last;
   modport source (output valid, status, phys_lba, sector_count, need_cluster, last,
                   input ready);
   modport sink (input valid, status, phys_lba, sector_count, need_cluster, last,
                 output ready);
endinterface

// ===== src/fcet_extent_mem.sv =====
// Extent table memory: one write port, one registered read port.
module fcet_extent_mem #(
   parameter int DEPTH = fcet_pkg::MAX_EXTENTS_DEF
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0]  wr_addr,
   input  fcet_pkg::extent_type                    wr_data,
   input  logic [((DEPTH>1)?$clog2(DEPTH):1)-1:0]  rd_addr,
   output fcet_pkg::extent_type                    rd_data
);
   import fcet_pkg::*;

   extent_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/fat_chain_extent_translator_top.sv =====
// FAT chain extent translator top level: map build sequencer and request splitter.
// Build: func 0 and func 1 work through the shared multiplier for extent lengths and starts.
// Requests: checks come first; each extent touched is found by a binary search
// through the table's registered read port.
// One item at a time; input is taken again while the last result waits.
// Reset is synchronous: control and CSRs return to defaults, the table is not cleared.
`include "fat_chain_extent_translator_top_assert.svh"

module fat_chain_extent_translator_top #(
   parameter int MAX_EXTENTS = fcet_pkg::MAX_EXTENTS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   fcet_req_if.sink                    req_ch,
   fcet_rsp_if.source                  rsp_ch,
   input  logic                        csr_we,
   input  logic [fcet_pkg::CSR_IW-1:0] csr_index,
   input  logic [fcet_pkg::CSR_DW-1:0] csr_wdata
);
   import fcet_pkg::*;

   localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
   localparam int TW = $clog2(MAX_EXTENTS + 1);

   state_type state_ff, state_in, ret_ff, ret_in;
   mode_type  mode_ff, mode_in;
   logic [TW-1:0] total_ff, total_in;
   logic [27:0] cur_ff, cur_in, rstart_ff, rstart_in, rcnt_ff, rcnt_in;
   logic [31:0] cov_ff, cov_in;

   logic [31:0] base_ff, cap_ff;
   logic [7:0]  spc_ff;
   logic [28:0] limit_ff;
   logic [27:0] scl_ff;
   logic        f32_ff, ro_ff;

   func_type    func_ff, func_in;
   logic [27:0] next_ff, next_in;
   logic [31:0] blk_ff, blk_in, num_ff, num_in;
   logic [32:0] end_ff, end_in;
   logic [35:0] prod_ff, prod_in;
   logic [31:0] len_ff, len_in;
   logic        brk_ff, brk_in, fin_ff, fin_in;
   logic [IW-1:0] lo_ff, lo_in, hi_ff, hi_in, addr_ff, addr_in;
   logic [31:0] off_ff, off_in, seg_len_ff, seg_len_in, seg_ps_ff, seg_ps_in;

   status_type  pst_ff, pst_in;
   logic [31:0] plba_ff, plba_in;
   logic [5:0]  pcnt_ff, pcnt_in;
   logic [27:0] pneed_ff, pneed_in;
   logic        plast_ff, plast_in;

   logic        ovld_ff;
   status_type  ost_ff;
   logic [31:0] olba_ff;
   logic [5:0]  ocnt_ff;
   logic [27:0] oneed_ff;
   logic        olast_ff;

   logic        wr_en;
   extent_type  wr_data, rd_data;

   logic [27:0] mul_a;
   logic [35:0] mul_p;
   logic [36:0] reach;
   logic [32:0] cov_sum;
   logic [IW:0] mid_w;
   logic [IW-1:0] mid, hi_init;
   logic [31:0] seg_n, seg_rem;
   logic        out_free, start_bad, link, next_bad, full, req_nrdy, bad_cnt;

   assign out_free  = !ovld_ff || rsp_ch.ready;
   assign mul_a     = (state_ff == ST_PMUL) ? (rstart_ff - 28'd2) : rcnt_ff;
   assign mul_p     = {8'd0, mul_a} * {28'd0, spc_ff};
   assign reach     = {5'd0, cov_ff} + {1'b0, prod_ff};
   assign cov_sum   = {1'b0, cov_ff} + {1'b0, len_ff};
   assign mid_w     = {1'b0, lo_ff} + {1'b0, hi_ff} + (IW+1)'(1);
   assign mid       = mid_w[IW:1];
   assign hi_init   = IW'(total_ff - TW'(1));
   assign start_bad = (scl_ff < 28'd2) || ({1'b0, scl_ff} >= limit_ff);
   assign link      = ({1'b0, next_ff} == ({1'b0, cur_ff} + 29'd1))
                      && ({1'b0, next_ff} < limit_ff);
   assign next_bad  = (next_ff < 28'd2) || ({1'b0, next_ff} >= limit_ff);
   assign full      = total_ff >= TW'(MAX_EXTENTS);
   assign req_nrdy  = (mode_ff != MODE_READY) || (total_ff == '0);
   assign bad_cnt   = (num_ff == 32'd0) || (num_ff > 32'(MAX_REQUEST_BLOCKS));
   assign seg_rem   = seg_len_ff - off_ff;
   assign seg_n     = (seg_rem > num_ff) ? num_ff : seg_rem;

   assign wr_data.first_block = cov_ff;
   assign wr_data.phys_start  = base_ff + prod_ff[31:0];
   assign wr_data.length      = len_ff;

   fcet_extent_mem #(
      .DEPTH (MAX_EXTENTS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IW'(total_ff)),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_ch.valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            case (func_ff)
               FUNC_BUILD: state_in = start_bad ? ST_OUT : ST_LMUL;
               FUNC_ENTRY: begin
                  if (mode_ff != MODE_BUILD) state_in = ST_OUT;
                  else if (link) state_in = ST_LMUL;
                  else if (full) state_in = ST_OUT;
                  else state_in = ST_LMUL;
               end
               default:    state_in = (req_nrdy || bad_cnt) ? ST_OUT : ST_RCHK;
            endcase
         end
         ST_LMUL:  state_in = brk_ff ? ST_PMUL : ST_ADV;
         ST_ADV:   state_in = (reach < {5'd0, cap_ff} || full) ? ST_OUT : ST_PMUL;
         ST_PMUL:  state_in = ST_PWR;
         ST_PWR:   state_in = brk_ff ? ST_CHAIN : ST_OUT;
         ST_CHAIN: state_in = next_bad ? ST_OUT : ST_LMUL;
         ST_RCHK: begin
            if (end_ff > {1'b0, cap_ff} || end_ff > {1'b0, cov_ff}) state_in = ST_OUT;
            else if (func_ff == FUNC_WRITE && ro_ff) state_in = ST_OUT;
            else state_in = ST_SSTEP;
         end
         ST_SSTEP: state_in = ST_SWAIT;
         ST_SWAIT: state_in = fin_ff ? ST_SOFF : ST_SCMP;
         ST_SCMP:  state_in = ST_SSTEP;
         ST_SOFF:  state_in = (rd_data.first_block > blk_ff) ? ST_IDLE : ST_SEMIT;
         ST_SEMIT: state_in = (off_ff >= seg_len_ff) ? ST_IDLE : ST_OUT;
         ST_OUT:   if (out_free) state_in = ret_ff;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mode_in    = mode_ff;
      total_in   = total_ff;
      cur_in     = cur_ff;
      rstart_in  = rstart_ff;
      rcnt_in    = rcnt_ff;
      cov_in     = cov_ff;
      func_in    = func_ff;
      next_in    = next_ff;
      blk_in     = blk_ff;
      num_in     = num_ff;
      end_in     = end_ff;
      prod_in    = prod_ff;
      len_in     = len_ff;
      brk_in     = brk_ff;
      fin_in     = fin_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      addr_in    = addr_ff;
      off_in     = off_ff;
      seg_len_in = seg_len_ff;
      seg_ps_in  = seg_ps_ff;
      pst_in     = pst_ff;
      plba_in    = plba_ff;
      pcnt_in    = pcnt_ff;
      pneed_in   = pneed_ff;
      plast_in   = plast_ff;
      ret_in     = ret_ff;
      wr_en      = 1'b0;
      req_ch.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            func_in   = func_type'(req_ch.func);
            next_in   = f32_ff ? (req_ch.entry_value[27:0] & FAT32_MASK)
                               : {12'd0, req_ch.entry_value[15:0]};
            blk_in    = req_ch.block;
            num_in    = req_ch.blk_count;
            plba_in   = '0;
            pcnt_in   = '0;
            pneed_in  = '0;
            plast_in  = 1'b1;
            ret_in    = ST_IDLE;
         end
         ST_DISPATCH: begin
            case (func_ff)
               FUNC_BUILD: begin
                  total_in = '0;
                  cov_in   = '0;
                  brk_in   = 1'b0;
                  if (start_bad) begin
                     mode_in = MODE_FAILED;
                     pst_in  = RS_FAILED;
                  end else begin
                     cur_in    = scl_ff;
                     rstart_in = scl_ff;
                     rcnt_in   = 28'd1;
                  end
               end
               FUNC_ENTRY: begin
                  if (mode_ff != MODE_BUILD) begin
                     pst_in = RS_NOT_READY;
                  end else if (link) begin
                     rcnt_in = rcnt_ff + 28'd1;
                     cur_in  = next_ff;
                     brk_in  = 1'b0;
                  end else if (full) begin
                     mode_in = MODE_FAILED;
                     pst_in  = RS_FAILED;
                  end else begin
                     brk_in = 1'b1;
                  end
               end
               default: begin
                  end_in = {1'b0, blk_ff} + {1'b0, num_ff};
                  if (req_nrdy) pst_in = RS_NOT_READY;
                  else pst_in = RS_BAD_COUNT;
               end
            endcase
         end
         ST_LMUL: prod_in = mul_p;
         ST_ADV: begin
            if (reach < {5'd0, cap_ff}) begin
               mode_in  = MODE_BUILD;
               pst_in   = RS_NEED;
               pneed_in = cur_ff;
            end else if (full) begin
               mode_in = MODE_FAILED;
               pst_in  = RS_FAILED;
            end
         end
         ST_PMUL: begin
            len_in  = (prod_ff[35:32] != 4'd0) ? 32'hFFFF_FFFF : prod_ff[31:0];
            prod_in = mul_p;
         end
         ST_PWR: begin
            wr_en    = 1'b1;
            total_in = total_ff + TW'(1);
            cov_in   = cov_sum[32] ? 32'hFFFF_FFFF : cov_sum[31:0];
            if (!brk_ff) begin
               mode_in = MODE_READY;
               pst_in  = RS_READY;
            end
         end
         ST_CHAIN: begin
            if (next_bad) begin
               mode_in = MODE_FAILED;
               pst_in  = RS_FAILED;
            end else begin
               rstart_in = next_ff;
               rcnt_in   = 28'd1;
               cur_in    = next_ff;
               brk_in    = 1'b0;
            end
         end
         ST_RCHK: begin
            pst_in = (end_ff > {1'b0, cap_ff} || end_ff > {1'b0, cov_ff})
                     ? RS_RANGE : RS_READ_ONLY;
            lo_in  = '0;
            hi_in  = hi_init;
         end
         ST_SSTEP: begin
            fin_in  = !(lo_ff < hi_ff);
            addr_in = (lo_ff < hi_ff) ? mid : lo_ff;
         end
         ST_SCMP: begin
            if (rd_data.first_block <= blk_ff) lo_in = addr_ff;
            else hi_in = addr_ff - IW'(1);
         end
         ST_SOFF: begin
            off_in     = blk_ff - rd_data.first_block;
            seg_len_in = rd_data.length;
            seg_ps_in  = rd_data.phys_start;
         end
         ST_SEMIT: begin
            pst_in   = RS_ACCESS;
            plba_in  = seg_ps_ff + off_ff;
            pcnt_in  = seg_n[5:0];
            pneed_in = '0;
            plast_in = (seg_n == num_ff);
            ret_in   = (seg_n == num_ff) ? ST_IDLE : ST_SSTEP;
            blk_in   = blk_ff + seg_n;
            num_in   = num_ff - seg_n;
            lo_in    = '0;
            hi_in    = hi_init;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_IDLE;
         total_ff <= '0;
         cur_ff   <= '0;
         rstart_ff <= '0;
         rcnt_ff  <= '0;
         cov_ff   <= '0;
         ovld_ff  <= 1'b0;
         base_ff  <= '0;
         spc_ff   <= 8'd1;
         limit_ff <= 29'd2;
         cap_ff   <= '0;
         scl_ff   <= '0;
         f32_ff   <= 1'b0;
         ro_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         total_ff  <= total_in;
         cur_ff    <= cur_in;
         rstart_ff <= rstart_in;
         rcnt_ff   <= rcnt_in;
         cov_ff    <= cov_in;
         if (state_ff == ST_OUT && out_free) ovld_ff <= 1'b1;
         else if (rsp_ch.ready) ovld_ff <= 1'b0;
         if (csr_we) begin
            case (csr_index)
               CSR_DATA_BASE: base_ff  <= csr_wdata;
               CSR_SPC:       spc_ff   <= csr_wdata[7:0];
               CSR_LIMIT:     limit_ff <= csr_wdata[28:0];
               CSR_CAPACITY:  cap_ff   <= csr_wdata;
               CSR_START:     scl_ff   <= csr_wdata[27:0];
               CSR_FAT32:     f32_ff   <= csr_wdata[0];
               CSR_READ_ONLY: ro_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      next_ff    <= next_in;
      blk_ff     <= blk_in;
      num_ff     <= num_in;
      end_ff     <= end_in;
      prod_ff    <= prod_in;
      len_ff     <= len_in;
      brk_ff     <= brk_in;
      fin_ff     <= fin_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      addr_ff    <= addr_in;
      off_ff     <= off_in;
      seg_len_ff <= seg_len_in;
      seg_ps_ff  <= seg_ps_in;
      pst_ff     <= pst_in;
      plba_ff    <= plba_in;
      pcnt_ff    <= pcnt_in;
      pneed_ff   <= pneed_in;
      plast_ff   <= plast_in;
      ret_ff     <= ret_in;
      if (state_ff == ST_OUT && out_free) begin
         ost_ff   <= pst_ff;
         olba_ff  <= plba_ff;
         ocnt_ff  <= pcnt_ff;
         oneed_ff <= pneed_ff;
         olast_ff <= plast_ff;
      end
   end

   assign rsp_ch.valid        = ovld_ff;
   assign rsp_ch.status       = ost_ff;
   assign rsp_ch.phys_lba     = olba_ff;
   assign rsp_ch.sector_count = ocnt_ff;
   assign rsp_ch.need_cluster = oneed_ff;
   assign rsp_ch.last         = olast_ff;

   `FCET_ASSERT_IMP(a_total_bound, clock, reset, 1'b1, total_ff <= TW'(MAX_EXTENTS))
   `FCET_ASSERT_IMP(a_access_count, clock, reset, ovld_ff && ost_ff == RS_ACCESS, ocnt_ff != 6'd0)
   `FCET_ASSERT_IMP(a_search_order, clock, reset, state_ff == ST_SSTEP, lo_ff <= hi_ff)
   `FCET_ASSERT_NXT(a_take_item, clock, reset, state_ff == ST_IDLE && req_ch.valid, state_ff == ST_DISPATCH)

endmodule
